// ===== rtl/erc_pkg.sv =====
// Shared widths, codes and control types of the elevator request controller.
`default_nettype none
package erc_pkg;

  localparam int FLOOR_W        = 5;
  localparam int COUNT_W        = 5;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;
  localparam int EVENT_W        = 3;
  localparam int DIR_W          = 2;
  localparam int MAX_FLOORS_DEF = 16;

  localparam logic [FLOOR_W-1:0] FLOOR_COUNT_RST = 5'd4;
  localparam logic [FLOOR_W-1:0] GROUND_FLOOR    = 5'd1;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HALL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CABIN = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 2'd0,
    ST_RANGE = 2'd1,
    ST_DUP   = 2'd2,
    ST_PRIO  = 2'd3
  } status_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_IDLE   = 3'd1,
    EV_UP     = 3'd2,
    EV_DOWN   = 3'd3,
    EV_ARRIVE = 3'd4,
    EV_LIMIT  = 3'd5
  } event_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2,
    DIR_STOP = 2'd3
  } dir_t;

  // What every cell of the queue row does in this cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_HEAD,
    CELL_PUSH_TAIL,
    CELL_MOVE_TAIL,
    CELL_POP_TAIL
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [FLOOR_W-1:0]   fl;
    logic [COUNT_W-1:0]   len;
  } cell_ctrl_t;

  typedef struct packed {
    status_t              status;
    event_t               event_code;
    logic [FLOOR_W-1:0]   car;
    dir_t                 dir;
    logic [COUNT_W-1:0]   len;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/erc_in_if.sv =====
// Input channel of the elevator request controller: command and floor.
`default_nettype none
interface erc_in_if;
  logic                          valid;
  logic                          ready;
  logic [erc_pkg::CMD_W-1:0]     cmd;
  logic [erc_pkg::FLOOR_W-1:0]   floor;

  modport source (output valid, output cmd, output floor, input ready);
  modport sink   (input valid, input cmd, input floor, output ready);
endinterface
`default_nettype wire

// ===== rtl/erc_out_if.sv =====
// Result channel of the elevator request controller.
`default_nettype none
interface erc_out_if;
  logic                          valid;
  logic                          ready;
  logic [erc_pkg::STATUS_W-1:0]  request_status;
  logic [erc_pkg::EVENT_W-1:0]   tick_event;
  logic [erc_pkg::FLOOR_W-1:0]   current_floor;
  logic [erc_pkg::DIR_W-1:0]     direction;
  logic                          target_valid;
  logic [erc_pkg::FLOOR_W-1:0]   target_floor;
  logic [erc_pkg::COUNT_W-1:0]   pending_count;

  modport source (output valid, output request_status, output tick_event,
                  output current_floor, output direction, output target_valid,
                  output target_floor, output pending_count, input ready);
  modport sink   (input valid, input request_status, input tick_event,
                  input current_floor, input direction, input target_valid,
                  input target_floor, input pending_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/erc_cell.sv =====
// One queue slot: holds a floor, matches it and shifts with its neighbors.
`default_nettype none
module erc_cell #(
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  wire erc_pkg::cell_ctrl_t     ctrl,
  input  wire [erc_pkg::FLOOR_W-1:0]   lower_floor,
  input  wire [erc_pkg::FLOOR_W-1:0]   upper_floor,
  input  wire                          above_in,
  output logic                         above_out,
  output logic                         hit,
  output logic [erc_pkg::FLOOR_W-1:0]  floor_q
);

  localparam logic [erc_pkg::COUNT_W-1:0] MY_IDX = erc_pkg::COUNT_W'(IDX);

  logic [erc_pkg::FLOOR_W-1:0] floor_r;
  logic [erc_pkg::FLOOR_W-1:0] floor_nxt;
  logic                        in_queue;

  assign in_queue  = MY_IDX < ctrl.len;
  assign hit       = in_queue && (floor_r == ctrl.fl);
  // True when the matching entry sits in this slot or farther from the tail.
  assign above_out = above_in | hit;
  assign floor_q   = floor_r;

  always_comb begin
    floor_nxt = floor_r;
    case (ctrl.op)
      erc_pkg::CELL_HOLD: begin
        floor_nxt = floor_r;
      end
      erc_pkg::CELL_PUSH_HEAD: begin
        if (MY_IDX == ctrl.len) begin
          floor_nxt = ctrl.fl;
        end
      end
      erc_pkg::CELL_PUSH_TAIL: begin
        floor_nxt = lower_floor;
      end
      erc_pkg::CELL_MOVE_TAIL: begin
        if (above_out) begin
          floor_nxt = lower_floor;
        end
      end
      erc_pkg::CELL_POP_TAIL: begin
        floor_nxt = upper_floor;
      end
      default: begin
        floor_nxt = floor_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    floor_r <= floor_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/erc_ctrl.sv =====
// Command decode, car movement, queue length and result registers.
`default_nettype none
module erc_ctrl #(
  parameter int MAX_FLOORS = erc_pkg::MAX_FLOORS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [erc_pkg::FLOOR_W-1:0]   cfg_wdata,
  input  wire                          in_valid,
  input  wire [erc_pkg::CMD_W-1:0]     in_cmd,
  input  wire [erc_pkg::FLOOR_W-1:0]   in_floor,
  output logic                         in_ready,
  input  wire                          out_ready,
  output logic                         out_valid,
  input  wire                          any_match,
  input  wire [erc_pkg::FLOOR_W-1:0]   tail_floor,
  output erc_pkg::cell_ctrl_t          cell_ctrl,
  output erc_pkg::result_t             res
);

  localparam logic [erc_pkg::COUNT_W-1:0] MAX_LEN = erc_pkg::COUNT_W'(MAX_FLOORS);
  localparam logic [erc_pkg::FLOOR_W-1:0] MAX_FL  = erc_pkg::FLOOR_W'(MAX_FLOORS);

  logic [erc_pkg::FLOOR_W-1:0] floor_count_r;
  logic [erc_pkg::COUNT_W-1:0] len_r, len_nxt;
  logic [erc_pkg::FLOOR_W-1:0] car_r, car_nxt;
  erc_pkg::dir_t               dir_r, dir_nxt;
  erc_pkg::status_t            status_r, status_nxt;
  erc_pkg::event_t             event_r, event_nxt;
  logic                        out_valid_r, out_valid_nxt;
  erc_pkg::cell_op_t           op;
  logic [erc_pkg::FLOOR_W-1:0] eff_count;
  logic                        in_fire, out_fire, in_range, full;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;

  assign eff_count = (floor_count_r > MAX_FL) ? MAX_FL : floor_count_r;
  assign in_range  = (in_floor != '0) && (in_floor <= eff_count);
  assign full      = len_r >= MAX_LEN;

  always_comb begin
    len_nxt    = len_r;
    car_nxt    = car_r;
    dir_nxt    = dir_r;
    status_nxt = erc_pkg::ST_ADDED;
    event_nxt  = erc_pkg::EV_NONE;
    op         = erc_pkg::CELL_HOLD;
    if (in_fire) begin
      case (in_cmd)
        erc_pkg::CMD_TICK: begin
          if (len_r == '0) begin
            dir_nxt   = erc_pkg::DIR_IDLE;
            event_nxt = erc_pkg::EV_IDLE;
          end else if (tail_floor > car_r) begin
            if (car_r >= eff_count) begin
              dir_nxt   = erc_pkg::DIR_STOP;
              event_nxt = erc_pkg::EV_LIMIT;
            end else begin
              dir_nxt   = erc_pkg::DIR_UP;
              event_nxt = erc_pkg::EV_UP;
              car_nxt   = car_r + 1'b1;
            end
          end else if (tail_floor < car_r) begin
            if (car_r <= erc_pkg::GROUND_FLOOR) begin
              dir_nxt   = erc_pkg::DIR_STOP;
              event_nxt = erc_pkg::EV_LIMIT;
            end else begin
              dir_nxt   = erc_pkg::DIR_DOWN;
              event_nxt = erc_pkg::EV_DOWN;
              car_nxt   = car_r - 1'b1;
            end
          end else begin
            dir_nxt   = erc_pkg::DIR_STOP;
            event_nxt = erc_pkg::EV_ARRIVE;
            op        = erc_pkg::CELL_POP_TAIL;
            len_nxt   = len_r - 1'b1;
          end
        end
        erc_pkg::CMD_HALL: begin
          if (!in_range) begin
            status_nxt = erc_pkg::ST_RANGE;
          end else if (any_match || full) begin
            status_nxt = erc_pkg::ST_DUP;
          end else begin
            op      = erc_pkg::CELL_PUSH_HEAD;
            len_nxt = len_r + 1'b1;
          end
        end
        erc_pkg::CMD_CABIN: begin
          if (!in_range) begin
            status_nxt = erc_pkg::ST_RANGE;
          end else if (any_match) begin
            status_nxt = erc_pkg::ST_PRIO;
            op         = erc_pkg::CELL_MOVE_TAIL;
          end else if (full) begin
            status_nxt = erc_pkg::ST_DUP;
          end else begin
            op      = erc_pkg::CELL_PUSH_TAIL;
            len_nxt = len_r + 1'b1;
          end
        end
        default: begin
          op = erc_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_count_r <= erc_pkg::FLOOR_COUNT_RST;
      len_r         <= '0;
      car_r         <= erc_pkg::GROUND_FLOOR;
      dir_r         <= erc_pkg::DIR_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        floor_count_r <= cfg_wdata;
      end
      len_r       <= len_nxt;
      car_r       <= car_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      event_r  <= event_nxt;
    end
  end

  assign cell_ctrl.op  = op;
  assign cell_ctrl.fl  = in_floor;
  assign cell_ctrl.len = len_r;

  // State registers double as the result register: they only change on an
  // accepted beat, which cannot happen while a result is stalled.
  assign res.status     = status_r;
  assign res.event_code = event_r;
  assign res.car        = car_r;
  assign res.dir        = dir_r;
  assign res.len        = len_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MAX_LEN)
    else $error("queue length exceeds the cell count");

  a_len_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(len_r))
    else $error("queue length changed without an accepted beat");

  a_car_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (car_r != $past(car_r))) |->
      ((car_r == $past(car_r) + 1'b1) || (car_r == $past(car_r) - 1'b1)))
    else $error("car moved by more than one floor");

  a_empty_tick_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == erc_pkg::CMD_TICK) && (len_r == '0)) |=>
      (dir_r == erc_pkg::DIR_IDLE) && (event_r == erc_pkg::EV_IDLE))
    else $error("tick on an empty queue did not idle the car");
`endif

endmodule
`default_nettype wire

// ===== rtl/elevator_request_controller_unit.sv =====
// Top level of the elevator request controller: control unit and queue cell row.
// A result is valid the cycle after its beat is accepted.
// Throughput: one command or tick per cycle unless a result is stalled; every cell
// compares and shifts in the accept cycle, and the match flag ripples once along the cell row.
// Reset clears length, car floor (to one), direction and floor count (to four);
// queue cell contents stay undefined, so no clearing pass is needed.
`default_nettype none
module elevator_request_controller_unit #(
  parameter int MAX_FLOORS = erc_pkg::MAX_FLOORS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [erc_pkg::FLOOR_W-1:0]   cfg_wdata,
  erc_in_if.sink                       in_ch,
  erc_out_if.source                    out_ch
);

  erc_pkg::cell_ctrl_t         cell_ctrl;
  erc_pkg::result_t            res;
  logic [erc_pkg::FLOOR_W-1:0] floor_q [MAX_FLOORS];
  logic [MAX_FLOORS:0]         above;
  logic [MAX_FLOORS-1:0]       hit;
  logic                        out_valid;
  logic                        in_ready;

  erc_ctrl #(
    .MAX_FLOORS (MAX_FLOORS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_floor   (in_ch.floor),
    .in_ready   (in_ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .any_match  (above[0]),
    .tail_floor (floor_q[0]),
    .cell_ctrl  (cell_ctrl),
    .res        (res)
  );

  assign above[MAX_FLOORS] = 1'b0;

  // Cell 0 holds the tail, the floor served next.
  for (genvar g = 0; g < MAX_FLOORS; g++) begin : g_cell
    logic [erc_pkg::FLOOR_W-1:0] lower;
    logic [erc_pkg::FLOOR_W-1:0] upper;
    if (g == 0) begin : g_low
      assign lower = cell_ctrl.fl;
    end else begin : g_low
      assign lower = floor_q[g-1];
    end
    if (g == MAX_FLOORS - 1) begin : g_up
      assign upper = floor_q[g];
    end else begin : g_up
      assign upper = floor_q[g+1];
    end
    erc_cell #(
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .lower_floor (lower),
      .upper_floor (upper),
      .above_in    (above[g+1]),
      .above_out   (above[g]),
      .hit         (hit[g]),
      .floor_q     (floor_q[g])
    );
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.request_status = res.status;
  assign out_ch.tick_event     = res.event_code;
  assign out_ch.current_floor  = res.car;
  assign out_ch.direction      = res.dir;
  assign out_ch.target_valid   = (res.len != '0);
  assign out_ch.target_floor   = (res.len != '0) ? floor_q[0] : '0;
  assign out_ch.pending_count  = res.len;

`ifndef NO_ASSERTIONS
  a_unique_floor: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("a floor is queued in more than one cell");
`endif

endmodule
`default_nettype wire
